### src/mla_pkg.sv
// Shared types and constants for the link accept block.
`default_nettype none

package mla_pkg;

  // Pipeline depth of one cosine lane and of the accept path
  localparam int COS_LAT = 6;
  localparam int ACC_LAT = 17;
  localparam int TOT_LAT = COS_LAT + ACC_LAT;

  // Output queue; it must hold every request that can be in flight
  localparam int FIFO_DEPTH = 32;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [15:0] BETA_RESET = 16'd256;

  // Reciprocals 2^31 / k rounded up, for k = 1 .. 6 (index k - 1)
  localparam logic [31:0] DIV_RECIP [6] = '{
    32'h8000_0000, 32'h4000_0000, 32'd715827883,
    32'h2000_0000, 32'd429496730, 32'd357913942
  };

  // Signed cosine in Q16, range -65536 .. 65536
  typedef logic signed [17:0] cos_t;

  // Fields that ride alongside the arithmetic pipeline
  typedef struct packed {
    logic [15:0] old_lo;
    logic [15:0] new_lo;
    logic [15:0] draw;
  } side_t;

  // One result entry
  typedef struct packed {
    logic        accepted;
    logic [15:0] link_out;
  } res_t;

  // Output queue status
  typedef struct packed {
    logic             not_empty;
    logic [CNT_W-1:0] count;
  } fifo_stat_t;

endpackage

`default_nettype wire

### src/mla_if.sv
// Valid/ready channel interfaces for requests and results.
`default_nettype none

interface mla_in_if;
  logic               valid;
  logic               ready;
  logic        [15:0] old_phase;
  logic signed [15:0] proposal_step;
  logic        [15:0] staple_a;
  logic        [15:0] staple_b;
  logic        [15:0] staple_c;
  logic        [15:0] staple_d;
  logic        [15:0] uniform_draw;

  modport source (output valid, old_phase, proposal_step, staple_a, staple_b,
                  staple_c, staple_d, uniform_draw, input ready);
  modport sink (input valid, old_phase, proposal_step, staple_a, staple_b,
                staple_c, staple_d, uniform_draw, output ready);
endinterface

interface mla_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [15:0] link_out;

  modport source (output valid, accepted, link_out, input ready);
  modport sink (input valid, accepted, link_out, output ready);
endinterface

`default_nettype wire

### src/mla_cos_lane.sv
// One cosine lane: cos(link + staple) in Q16 over a six-stage pipeline.
`default_nettype none

module mla_cos_lane #(
  parameter int PHASE_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic [PHASE_BITS-1:0] link,
  input  wire logic [15:0]           staple,
  output mla_pkg::cos_t              cos_q
);

  logic [PHASE_BITS-1:0] phase;
  logic [15:0]           turn;
  logic [1:0]            quad;
  logic [13:0]           x;

  logic [14:0] xe_r;
  logic        neg1_r;
  logic [29:0] sq;
  logic [16:0] s2_r;
  logic        neg2_r;
  logic [22:0] p60;
  logic [16:0] s3_r;
  logic [10:0] a0_r;
  logic        neg3_r;
  logic [27:0] p1;
  logic [16:0] s4_r;
  logic [14:0] a1_r;
  logic        neg4_r;
  logic [31:0] p2;
  logic [16:0] s5_r;
  logic [16:0] a2_r;
  logic        neg5_r;
  logic [33:0] p3;
  logic [17:0] d;
  logic [16:0] pmag;
  mla_pkg::cos_t cos_nxt;
  mla_pkg::cos_t cos_r;

  // Wrap the angle sum in the phase range
  assign phase = link + PHASE_BITS'(staple);

  // Scale the phase to a 16-bit turn
  generate
    if (PHASE_BITS >= 16) begin : g_wide
      assign turn = phase[PHASE_BITS-1 -: 16];
    end else begin : g_narrow
      assign turn = {phase, {(16 - PHASE_BITS){1'b0}}};
    end
  endgenerate

  // Fold the quadrant onto the first one
  assign quad = turn[15:14];
  assign x    = turn[13:0];

  always_ff @(posedge clk) begin
    xe_r   <= quad[0] ? 15'(15'd16384 - {1'b0, x}) : {1'b0, x};
    neg1_r <= quad[1] ^ quad[0];
  end

  // Square: s = (4x)^2 / 2^16
  assign sq = 30'(xe_r) * 30'(xe_r);

  always_ff @(posedge clk) begin
    s2_r   <= sq[28:12];
    neg2_r <= neg1_r;
  end

  // Horner step one
  assign p60 = 23'(s2_r) * 23'd60;

  always_ff @(posedge clk) begin
    s3_r   <= s2_r;
    a0_r   <= 11'(11'd1367 - 11'(p60[22:16]));
    neg3_r <= neg2_r;
  end

  // Horner step two
  assign p1 = 28'(s3_r) * 28'(a0_r);

  always_ff @(posedge clk) begin
    s4_r   <= s3_r;
    a1_r   <= 15'(15'd16625 - 15'(p1[27:16]));
    neg4_r <= neg3_r;
  end

  // Horner step three
  assign p2 = 32'(s4_r) * 32'(a1_r);

  always_ff @(posedge clk) begin
    s5_r   <= s4_r;
    a2_r   <= 17'(17'd80852 - 17'(p2[31:16]));
    neg5_r <= neg4_r;
  end

  // Final product, clamp at zero and apply the quadrant sign
  assign p3   = 34'(s5_r) * 34'(a2_r);
  assign d    = p3[33:16];
  assign pmag = (d >= 18'd65536) ? 17'd0 : 17'(18'd65536 - d);

  always_comb begin
    if (neg5_r) begin
      cos_nxt = mla_pkg::cos_t'(18'(-{1'b0, pmag}));
    end else begin
      cos_nxt = mla_pkg::cos_t'({1'b0, pmag});
    end
  end

  always_ff @(posedge clk) begin
    cos_r <= cos_nxt;
  end

  assign cos_q = cos_r;

endmodule

`default_nettype wire

### src/mla_accept.sv
// Merge of the lane cosines and the pipelined exp(-x) accept test.
`default_nettype none

module mla_accept (
  input  wire logic          clk,
  input  wire mla_pkg::cos_t cos_old [4],
  input  wire mla_pkg::cos_t cos_new [4],
  input  wire logic [15:0]   beta,
  input  wire logic [15:0]   draw,
  output logic               take
);

  typedef struct packed {
    logic        nonneg;
    logic [12:0] n;
    logic [15:0] u;
  } exp_ctl_t;

  logic signed [19:0] sum_old;
  logic signed [19:0] sum_new;
  logic signed [20:0] delta_r;
  logic [19:0]        mag;
  logic [35:0]        pm;
  logic [27:0]        m_r;
  logic               nonneg2_r;
  logic [44:0]        py;
  logic [15:0]        f_r;
  logic [12:0]        n3_r;
  logic               nonneg3_r;
  logic [31:0]        pu;
  exp_ctl_t           ctl4_r;

  exp_ctl_t    ctl_a_r [6];
  logic [15:0] q_r     [6];
  exp_ctl_t    ctl_b_r [6];
  logic [16:0] h_r     [6];

  logic [16:0] limit;
  logic        take_r;

  // Merge the lanes: sums over the four staples and their difference
  assign sum_old = 20'(cos_old[0]) + 20'(cos_old[1]) + 20'(cos_old[2]) + 20'(cos_old[3]);
  assign sum_new = 20'(cos_new[0]) + 20'(cos_new[1]) + 20'(cos_new[2]) + 20'(cos_new[3]);

  always_ff @(posedge clk) begin
    delta_r <= 21'(sum_new) - 21'(sum_old);
  end

  // Scale the magnitude by beta
  assign mag = 20'(-delta_r);
  assign pm  = 36'(beta) * 36'(mag);

  always_ff @(posedge clk) begin
    m_r       <= pm[35:8];
    nonneg2_r <= ~delta_r[20];
  end

  // Divide by ln2 and split into integer and fraction
  assign py = 45'(m_r) * 45'(17'd94548);

  always_ff @(posedge clk) begin
    n3_r      <= py[44:32];
    f_r       <= py[31:16];
    nonneg3_r <= nonneg2_r;
  end

  // Scale the fraction back by ln2
  assign pu = 32'(f_r) * 32'(16'd45426);

  always_ff @(posedge clk) begin
    ctl4_r.nonneg <= nonneg3_r;
    ctl4_r.n      <= n3_r;
    ctl4_r.u      <= pu[31:16];
  end

  // Nested series for exp(-u), one k per pair of stages, k from six down to one
  generate
    for (genvar j = 0; j < 6; j++) begin : g_exp
      exp_ctl_t    ctl_in;
      logic [16:0] h_in;
      logic [32:0] pq;
      logic [47:0] pd;

      if (j == 0) begin : g_first
        assign ctl_in = ctl4_r;
        assign h_in   = 17'd65536;
      end else begin : g_next
        assign ctl_in = ctl_b_r[j-1];
        assign h_in   = h_r[j-1];
      end

      assign pq = 33'(ctl_in.u) * 33'(h_in);

      always_ff @(posedge clk) begin
        q_r[j]     <= pq[31:16];
        ctl_a_r[j] <= ctl_in;
      end

      // Divide by k through its reciprocal
      assign pd = 48'(q_r[j]) * 48'(mla_pkg::DIV_RECIP[5-j]);

      always_ff @(posedge clk) begin
        h_r[j]     <= 17'(17'd65536 - 17'(pd[46:31]));
        ctl_b_r[j] <= ctl_a_r[j];
      end
    end
  endgenerate

  // Apply 2^-n and compare against the draw; a non-negative difference is always taken
  assign limit = (ctl_b_r[5].n > 13'd16) ? 17'd0 : (h_r[5] >> ctl_b_r[5].n[4:0]);

  always_ff @(posedge clk) begin
    take_r <= ctl_b_r[5].nonneg | ({1'b0, draw} < limit);
  end

  assign take = take_r;

endmodule

`default_nettype wire

### src/mla_out_fifo.sv
// Result queue between the pipeline and the output channel.
`default_nettype none

module mla_out_fifo (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire mla_pkg::res_t    push_data,
  input  wire logic             pop,
  output mla_pkg::res_t         head,
  output mla_pkg::fifo_stat_t   stat
);

  localparam int PW = mla_pkg::PTR_W;
  localparam int CW = mla_pkg::CNT_W;

  mla_pkg::res_t mem_r [mla_pkg::FIFO_DEPTH];
  mla_pkg::res_t head_r;
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  // Store the incoming result
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PW'(push);
    rd_ptr_nxt = rd_ptr_r + PW'(pop);
    count_nxt  = count_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Prefetch the next head; bypass a result written into the head slot
  always_ff @(posedge clk) begin
    if (push && (wr_ptr_r == rd_ptr_nxt)) begin
      head_r <= push_data;
    end else begin
      head_r <= mem_r[rd_ptr_nxt];
    end
  end

  assign head           = head_r;
  assign stat.not_empty = (count_r != '0);
  assign stat.count     = count_r;

`ifndef NO_ASSERTIONS
  // The credit scheme must never push into a full queue
  assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r < CW'(mla_pkg::FIFO_DEPTH)) || pop)
    else $error("result queue overflow");
`endif

endmodule

`default_nettype wire

### src/metropolis_link_accept_core.sv
// Top level of the Metropolis accept test for one U(1) link.
//
// Each request carries the old link phase, a signed step, four staple phases
// and a uniform draw; the block returns the accept flag and the resulting
// link, one result per request, in order. A new request is taken every clock
// cycle while in_chan.ready is high; the result passes six stages in the eight
// parallel cosine lanes and seventeen in the merge and exp(-x) pipeline, and
// may then wait in the 32-entry result queue. Up to 32
// requests may be outstanding; in_chan.ready drops only when the queue and
// the pipeline together hold that many. coupling_beta is written through
// cfg_we/cfg_wdata and should change only while no request is in flight.
`default_nettype none

module metropolis_link_accept_core #(
  parameter int PHASE_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  mla_in_if.sink           in_chan,
  mla_out_if.source        out_chan,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);

  localparam int TOT = mla_pkg::TOT_LAT;
  localparam int CW  = mla_pkg::CNT_W;

  logic                  in_acc;
  logic                  out_acc;
  logic [15:0]           beta_r;
  logic [CW-1:0]         credit_r, credit_nxt;
  logic [PHASE_BITS-1:0] old_w;
  logic [PHASE_BITS-1:0] new_w;
  logic [15:0]           staple_w [4];
  mla_pkg::cos_t         cos_old [4];
  mla_pkg::cos_t         cos_new [4];
  logic [TOT-1:0]        vld_r;
  mla_pkg::side_t        side_r [TOT];
  logic                  take;
  mla_pkg::res_t         push_data;
  mla_pkg::res_t         head;
  mla_pkg::fifo_stat_t   fstat;

  // Handshakes
  assign in_chan.ready = (credit_r < CW'(mla_pkg::FIFO_DEPTH));
  assign in_acc        = in_chan.valid & in_chan.ready;
  assign out_acc       = fstat.not_empty & out_chan.ready;

  // Hold the coupling register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beta_r <= mla_pkg::BETA_RESET;
    end else if (cfg_we) begin
      beta_r <= cfg_wdata;
    end
  end

  // Count requests taken but not yet delivered
  assign credit_nxt = credit_r + CW'(in_acc) - CW'(out_acc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
    end else begin
      credit_r <= credit_nxt;
    end
  end

  // Form old and proposed link in the phase range
  assign old_w = PHASE_BITS'(in_chan.old_phase);
  assign new_w = old_w + PHASE_BITS'(in_chan.proposal_step);

  assign staple_w[0] = in_chan.staple_a;
  assign staple_w[1] = in_chan.staple_b;
  assign staple_w[2] = in_chan.staple_c;
  assign staple_w[3] = in_chan.staple_d;

  // Eight cosine lanes: four staples against the old and the new link
  generate
    for (genvar i = 0; i < 4; i++) begin : g_lane
      mla_cos_lane #(.PHASE_BITS(PHASE_BITS)) u_old (
        .clk    (clk),
        .link   (old_w),
        .staple (staple_w[i]),
        .cos_q  (cos_old[i])
      );
      mla_cos_lane #(.PHASE_BITS(PHASE_BITS)) u_new (
        .clk    (clk),
        .link   (new_w),
        .staple (staple_w[i]),
        .cos_q  (cos_new[i])
      );
    end
  endgenerate

  mla_accept u_accept (
    .clk     (clk),
    .cos_old (cos_old),
    .cos_new (cos_new),
    .beta    (beta_r),
    .draw    (side_r[TOT-2].draw),
    .take    (take)
  );

  // Carry request valid alongside the arithmetic
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[TOT-2:0], in_acc};
    end
  end

  // Carry links and draw alongside the arithmetic
  always_ff @(posedge clk) begin
    side_r[0].old_lo <= 16'(old_w);
    side_r[0].new_lo <= 16'(new_w);
    side_r[0].draw   <= in_chan.uniform_draw;
    for (int k = 1; k < TOT; k++) begin
      side_r[k] <= side_r[k-1];
    end
  end

  // Pick the resulting link and queue the result
  assign push_data.accepted = take;
  assign push_data.link_out = take ? side_r[TOT-1].new_lo : side_r[TOT-1].old_lo;

  mla_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (vld_r[TOT-1]),
    .push_data (push_data),
    .pop       (out_acc),
    .head      (head),
    .stat      (fstat)
  );

  assign out_chan.valid    = fstat.not_empty;
  assign out_chan.accepted = head.accepted;
  assign out_chan.link_out = head.link_out;

`ifndef NO_ASSERTIONS
  // Outstanding requests never exceed the queue depth
  assert property (@(posedge clk) disable iff (!rst_n)
    credit_r <= CW'(mla_pkg::FIFO_DEPTH))
    else $error("credit count above queue depth");

  // Every queued result is still counted as outstanding
  assert property (@(posedge clk) disable iff (!rst_n)
    fstat.count <= credit_r)
    else $error("queue holds more than the outstanding requests");

  // A delivered result always belongs to a taken request
  assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> credit_r != '0)
    else $error("result delivered with no request outstanding");
`endif

endmodule

`default_nettype wire

### sim/mla_link_checker.sv
// Scoreboard for the link accept block: predicts every result from the request and compares.
`timescale 1ns / 100ps

module mla_link_checker #(
  parameter int PHASE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  mla_in_if           in_chan,
  mla_out_if          out_chan,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output int          mismatch_count,
  output int          pending_results,
  output int          requests_taken
);

  localparam logic [63:0] PHASE_MASK = (64'd1 << PHASE_BITS) - 64'd1;
  localparam int SCALE_UP = (PHASE_BITS < 16) ? 16 - PHASE_BITS : 0;
  localparam int SCALE_DN = (PHASE_BITS > 16) ? PHASE_BITS - 16 : 0;
  localparam logic [15:0] BETA_AFTER_RESET = 16'd256;

  logic [15:0]     coupling_beta;
  mla_pkg::res_t   expected_links [$];
  mla_pkg::res_t   oldest;

  // Polynomial for cos(pi/2 * x / 16384), x in 0 .. 16384, Q16
  function automatic logic [63:0] quarter_wave_cos(input logic [63:0] x);
    logic [63:0] t, s, a, d;
    t = x << 2;
    s = (t * t) >> 16;
    a = 64'd1367 - ((s * 64'd60) >> 16);
    a = 64'd16625 - ((s * a) >> 16);
    a = 64'd80852 - ((s * a) >> 16);
    d = (s * a) >> 16;
    return (d >= 64'd65536) ? 64'd0 : 64'd65536 - d;
  endfunction

  // Signed cosine of a phase, scaled to 16 bits, quadrant by the top two bits
  function automatic longint phase_cosine(input logic [63:0] phase);
    logic [63:0] u, x;
    u = (((phase & PHASE_MASK) << SCALE_UP) >> SCALE_DN) & 64'hFFFF;
    x = u & 64'h3FFF;
    case (u[15:14])
      2'd0: return longint'(quarter_wave_cos(x));
      2'd1: return -longint'(quarter_wave_cos(64'd16384 - x));
      2'd2: return -longint'(quarter_wave_cos(x));
      default: return longint'(quarter_wave_cos(64'd16384 - x));
    endcase
  endfunction

  function automatic longint cos_sum_over_staples(input logic [63:0] link,
                                                  input logic [3:0][15:0] staples);
    longint sum;
    sum = 0;
    for (int i = 0; i < 4; i++)
      sum += phase_cosine(link + {48'd0, staples[i]});
    return sum;
  endfunction

  // exp(-m) in Q16 as 2^-n times a short series for the fraction
  function automatic logic [63:0] neg_exp_limit(input logic [63:0] m);
    logic [63:0] y, n, f, u, h, k;
    y = (m * 64'd94548) >> 16;
    n = y >> 16;
    f = y & 64'hFFFF;
    u = (f * 64'd45426) >> 16;
    h = 64'd65536;
    if (n > 64'd16)
      return 64'd0;
    for (k = 64'd6; k >= 64'd1; k--)
      h = 64'd65536 - (u * h) / (k * 64'd65536);
    return h >> n;
  endfunction

  function automatic mla_pkg::res_t predict_link_update(
      input logic [15:0] old_in, input logic signed [15:0] step,
      input logic [3:0][15:0] staples, input logic [15:0] draw,
      input logic [15:0] beta);
    logic [63:0]   cur_link, prop_link, step_wide, mag, m;
    longint        delta;
    logic          take;
    mla_pkg::res_t r;
    cur_link  = {48'd0, old_in} & PHASE_MASK;
    step_wide = {{48{step[15]}}, step};
    prop_link = (cur_link + step_wide) & PHASE_MASK;
    delta = cos_sum_over_staples(prop_link, staples) - cos_sum_over_staples(cur_link, staples);
    if (delta >= 0) begin
      take = 1'b1;
    end else begin
      mag  = 64'(-delta);
      m    = ({48'd0, beta} * mag) >> 8;
      take = ({48'd0, draw} < neg_exp_limit(m));
    end
    r.accepted = take;
    r.link_out = take ? prop_link[15:0] : cur_link[15:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("%0t ns  mismatch: %s", $time, what);
  endtask

  // Track the register, retire results in order, queue a prediction per request
  always @(posedge clk) begin
    if (!rst_n) begin
      coupling_beta = BETA_AFTER_RESET;
      expected_links.delete();
    end else begin
      if (cfg_we)
        coupling_beta = cfg_wdata;
      if (out_chan.valid && out_chan.ready) begin
        if (expected_links.size() == 0) begin
          report_mismatch($sformatf("result with no request waiting: accepted=%b link=%h",
                                    out_chan.accepted, out_chan.link_out));
        end else begin
          oldest = expected_links.pop_front();
          if (out_chan.accepted !== oldest.accepted)
            report_mismatch($sformatf("accepted got %b want %b",
                                      out_chan.accepted, oldest.accepted));
          if (out_chan.link_out !== oldest.link_out)
            report_mismatch($sformatf("link_out got %h want %h",
                                      out_chan.link_out, oldest.link_out));
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        expected_links.push_back(predict_link_update(
            in_chan.old_phase, in_chan.proposal_step,
            {in_chan.staple_d, in_chan.staple_c, in_chan.staple_b, in_chan.staple_a},
            in_chan.uniform_draw, coupling_beta));
        requests_taken++;
      end
    end
    pending_results = expected_links.size();
  end

endmodule

### sim/tb_top.sv
// Testbench top for the link accept block: clock, reset, request and result traffic, verdict.
`timescale 1ns / 100ps

module tb_top;

  localparam int PHASE_BITS = 16;
  localparam int RANDOM_PHASES = 8;
  localparam int REQS_PER_PHASE = 190;
  localparam logic [15:0] BETA_PLAN [RANDOM_PHASES] = '{
    16'd65535, 16'd0, 16'd1, 16'd64, 16'd256, 16'd1024, 16'd6000, 16'd20000
  };

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  int          idle_pct;
  int          stall_pct;
  int          fail_count;
  int          pending_results;
  int          requests_taken;

  mla_in_if  in_chan ();
  mla_out_if out_chan ();

  metropolis_link_accept_core #(
    .PHASE_BITS (PHASE_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  mla_link_checker #(
    .PHASE_BITS (PHASE_BITS)
  ) checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_chan         (in_chan),
    .out_chan        (out_chan),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .mismatch_count  (fail_count),
    .pending_results (pending_results),
    .requests_taken  (requests_taken)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Stall the result side at random
  always @(negedge clk) begin
    out_chan.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Offer one request, idling first at random; return at the negedge after it is taken
  task automatic push_request(input logic [15:0] old_ph, input logic signed [15:0] step,
                              input logic [3:0][15:0] st, input logic [15:0] draw);
    int target;
    while ($urandom_range(99) < idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    target = requests_taken + 1;
    in_chan.valid         <= 1'b1;
    in_chan.old_phase     <= old_ph;
    in_chan.proposal_step <= step;
    in_chan.staple_a      <= st[0];
    in_chan.staple_b      <= st[1];
    in_chan.staple_c      <= st[2];
    in_chan.staple_d      <= st[3];
    in_chan.uniform_draw  <= draw;
    do @(negedge clk); while (requests_taken != target);
  endtask

  // Drop valid and hold until every expected result is back
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    while (pending_results != 0)
      @(negedge clk);
  endtask

  task automatic write_beta(input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random request: small steps for fine exponents, staples often aligned with the link
  task automatic push_random_request();
    logic [15:0]        old_ph, draw;
    logic signed [15:0] step;
    logic [3:0][15:0]   st;
    int                 pick;
    pick = $urandom_range(99);
    if (pick < 40) begin
      step = 16'($urandom_range(511));
      if ($urandom_range(1) == 1)
        step = -step;
    end else if (pick < 75) begin
      step = 16'($urandom);
    end else if (pick < 88) begin
      step = 16'($urandom_range(4095)) - 16'sd2048;
    end else begin
      case ($urandom_range(4))
        0: step = 16'sh8000;
        1: step = 16'sh7FFF;
        2: step = 16'sh0000;
        3: step = -16'sd1;
        default: step = 16'sd1;
      endcase
    end
    if ($urandom_range(6) == 0)
      old_ph = {2'($urandom_range(3)), 14'd0} + 16'($urandom_range(7)) - 16'd4;
    else
      old_ph = 16'($urandom);
    for (int i = 0; i < 4; i++) begin
      if (pick % 4 == 0)
        st[i] = 16'd0 - old_ph + 16'($urandom_range(255)) - 16'd128;
      else
        st[i] = 16'($urandom);
    end
    case ($urandom_range(9))
      0: draw = 16'h0000;
      1: draw = 16'hFFFF;
      default: draw = 16'($urandom);
    endcase
    push_request(old_ph, step, st, draw);
  endtask

  initial begin
    int phase_idx;
    int n;
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_wdata             = 16'd0;
    idle_pct              = 0;
    stall_pct             = 0;
    in_chan.valid         = 1'b0;
    in_chan.old_phase     = 16'd0;
    in_chan.proposal_step = 16'sd0;
    in_chan.staple_a      = 16'd0;
    in_chan.staple_b      = 16'd0;
    in_chan.staple_c      = 16'd0;
    in_chan.staple_d      = 16'd0;
    in_chan.uniform_draw  = 16'd0;
    out_chan.ready        = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Field extremes and quadrant edges at the reset coupling
    push_request(16'h0000, 16'sh0000, {4{16'h0000}}, 16'h0000);
    push_request(16'hFFFF, 16'sh7FFF, {4{16'hFFFF}}, 16'hFFFF);
    push_request(16'h0000, 16'sh8000, {4{16'h0000}}, 16'h0000);
    push_request(16'h0000, 16'sh8000, {4{16'h0000}}, 16'hFFFF);
    push_request(16'h3FFF, 16'sh0001, {4{16'h0000}}, 16'h8000);
    push_request(16'h4000, -16'sd1, {4{16'h0000}}, 16'h8000);
    push_request(16'h8000, 16'sh4000, {16'h4000, 16'hC000, 16'h8000, 16'h0000}, 16'h7FFF);
    push_request(16'hC000, 16'sh3FFF, {16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0}, 16'h0001);
    push_request(16'h0000, 16'sh0040, {4{16'h0000}}, 16'hF000);
    push_request(16'h5555, -16'sd64, {16'hAAAA, 16'h5555, 16'hFF00, 16'h00FF}, 16'h4000);

    // Zero coupling: any downhill proposal is taken
    drain_results();
    write_beta(16'd0);
    push_request(16'h0000, 16'sh8000, {4{16'h0000}}, 16'hFFFF);
    push_request(16'h0000, 16'sh2000, {4{16'h0000}}, 16'hFFFF);
    push_request(16'h1000, 16'sh4321, {16'hF000, 16'hF000, 16'h0000, 16'h0000}, 16'hFFFF);

    // Largest coupling: steep downhill moves are refused even for a zero draw
    drain_results();
    write_beta(16'hFFFF);
    push_request(16'h0000, 16'sh8000, {4{16'h0000}}, 16'h0000);
    push_request(16'h0000, -16'sd16384, {4{16'h0000}}, 16'h0000);
    push_request(16'h0000, 16'sh0008, {4{16'h0000}}, 16'h0000);
    push_request(16'h8000, 16'sh8000, {4{16'h8000}}, 16'h0000);

    // Random phases over couplings, idle and stall patterns
    for (phase_idx = 0; phase_idx < RANDOM_PHASES; phase_idx++) begin
      drain_results();
      write_beta(phase_idx == RANDOM_PHASES - 1 ? 16'($urandom) : BETA_PLAN[phase_idx]);
      case (phase_idx % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 78; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 78; end
        default: begin idle_pct = 9; stall_pct = 9; end
      endcase
      for (n = 0; n < REQS_PER_PHASE; n++) begin
        if (n == REQS_PER_PHASE / 2)
          drain_results();
        push_random_request();
      end
    end

    drain_results();
    repeat (mla_pkg::TOT_LAT + 8) @(negedge clk);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // Hard stop for a hung handshake
  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### metropolis_link_accept_core.f
src/mla_pkg.sv
src/mla_if.sv
src/mla_cos_lane.sv
src/mla_accept.sv
src/mla_out_fifo.sv
src/metropolis_link_accept_core.sv
sim/mla_link_checker.sv
sim/tb_top.sv
